[hw/rtl/mbrx_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus RTU receiver package
// Shared widths, codes and constants for the Modbus RTU frame receiver.
// ----------------------------------------------------------------------------
package mbrx_pkg;

	localparam int SILENCE_BITS = 16;
	localparam int TIMEOUT_BITS = 16;
	localparam int CMP_BITS     = (SILENCE_BITS > TIMEOUT_BITS) ? SILENCE_BITS : TIMEOUT_BITS;
	localparam int CFG_IDX_BITS = 8;
	localparam int CFG_DAT_BITS = 16;

	localparam logic [SILENCE_BITS-1:0] SILENCE_MAX = '1;
	localparam logic [15:0]             CRC_INIT    = 16'hFFFF;
	localparam logic [15:0]             CRC_POLY    = 16'hA001;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_STATION = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT = 8'd1;

	// Input commands
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// Result status codes
	localparam logic [2:0] ST_IGNORED  = 3'd0;
	localparam logic [2:0] ST_ADDRESS  = 3'd1;
	localparam logic [2:0] ST_FUNCTION = 3'd2;
	localparam logic [2:0] ST_BAD_FUNC = 3'd3;
	localparam logic [2:0] ST_DATA     = 3'd4;
	localparam logic [2:0] ST_CRC_LOW  = 3'd5;
	localparam logic [2:0] ST_FRAME_OK = 3'd6;
	localparam logic [2:0] ST_CRC_ERR  = 3'd7;

	// Function codes with a fixed or counted payload
	localparam logic [7:0] FC_FIXED_LO  = 8'd1;
	localparam logic [7:0] FC_FIXED_HI  = 8'd6;
	localparam logic [7:0] FC_WRITE_MUL = 8'd16;
	localparam logic [8:0] LEN_FIXED    = 9'd4;
	localparam logic [8:0] LEN_MUL_HEAD = 9'd5;

endpackage

[hw/rtl/mbrx_if.sv]
// ----------------------------------------------------------------------------
// Modbus RTU receiver channels
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface mbrx_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] rx_byte;

	modport source (output valid, command, rx_byte, input ready);
	modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface mbrx_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic       timeout_abort;
	logic [7:0] function_code;
	logic [8:0] data_index;
	logic [7:0] data_value;
	logic [8:0] payload_length;

	modport source (output valid, status, timeout_abort, function_code, data_index,
		data_value, payload_length, input ready);
	modport sink   (input valid, status, timeout_abort, function_code, data_index,
		data_value, payload_length, output ready);
endinterface

interface mbrx_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/modbus_rtu_frame_receiver.sv]
// ----------------------------------------------------------------------------
// Modbus RTU frame receiver
// Slave-side frame parser with streamed payload and CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// Usage:
//   req  - input channel; each transfer is one received byte (command 0) or
//          one time tick (command 1). Ticks advance the silence counter and
//          give no result; every byte gives exactly one result.
//   rsp  - result channel: status, timeout_abort, function_code, data_index,
//          data_value, payload_length for each byte.
//   cfg  - register writes: index 0 station address, index 1 timeout in ticks.
//          Other indexes are accepted and dropped. Write only while idle.
// Timing:
//   A byte transferred on req waits in the input register, runs through the
//   frame logic and the byte CRC update, and its result is loaded into the
//   result register and presented on rsp. One item per cycle is sustained
//   while rsp takes each result; the frame state (phase, counters, CRC) is
//   updated as each item advances, so each item sees the state left by the last.
// Reset:
//   arst_n clears the frame state, the CRC (to 0xFFFF) and the silence counter,
//   and sets the registers to address 1 and timeout 4.
// Backpressure:
//   While rsp is stalled the pending result holds; one more item waits in the
//   input register, ticks keep draining, and req drops ready when a byte is
//   stuck behind the stalled result.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_receiver
	import mbrx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mbrx_in_if.sink     req,
	mbrx_out_if.source  rsp,
	mbrx_cfg_if.sink    cfg
);

	localparam logic [2:0] PH_IDLE     = 3'd0;
	localparam logic [2:0] PH_ADDRESS  = 3'd1;
	localparam logic [2:0] PH_DATA     = 3'd2;
	localparam logic [2:0] PH_CRC_LOW  = 3'd3;
	localparam logic [2:0] PH_CRC_HIGH = 3'd4;

	// Configuration
	logic [7:0]              station_q;
	logic [TIMEOUT_BITS-1:0] timeout_q;

	// Input register
	logic       valid_s1;
	logic       command_s1;
	logic [7:0] byte_s1;

	// Frame state
	logic [2:0]              phase_q;
	logic [SILENCE_BITS-1:0] silence_q;
	logic [15:0]             crc_q;
	logic [7:0]              func_q;
	logic [8:0]              exp_q;
	logic [8:0]              rcv_q;
	logic [7:0]              crc_lo_q;

	// Result register
	logic       out_valid_q;
	logic [2:0] status_q;
	logic       abort_q;
	logic [7:0] func_out_q;
	logic [8:0] idx_q;
	logic [8:0] len_q;
	logic [7:0] val_q;

	logic       advance;
	logic       is_byte;
	logic       abort;
	logic [2:0] ph_cur;
	logic [2:0] ph_n;
	logic [15:0] crc_cur, crc_n, crc_upd;
	logic [7:0]  func_cur, func_n;
	logic [8:0]  exp_cur, exp_n;
	logic [8:0]  rcv_cur, rcv_n, rcv_inc;
	logic [7:0]  lo_cur, lo_n;
	logic [2:0]  st;
	logic [8:0]  idx;
	logic [7:0]  val;
	logic [CMP_BITS-1:0] silence_ext, timeout_ext;

	// Handshakes
	assign is_byte   = (command_s1 == CMD_BYTE);
	assign advance   = valid_s1 && (!is_byte || !out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			station_q <= 8'd1;
			timeout_q <= TIMEOUT_BITS'(4);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_STATION: station_q <= cfg.data[7:0];
				REG_TIMEOUT: timeout_q <= cfg.data[TIMEOUT_BITS-1:0];
				default: ; // drop writes beyond the register list
			endcase
		end
	end

	// Hold the transferred item until the frame logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			command_s1 <= req.command;
			byte_s1    <= req.rx_byte;
		end
	end

	// A frame in progress goes stale once silence exceeds the timeout
	assign silence_ext = CMP_BITS'(silence_q);
	assign timeout_ext = CMP_BITS'(timeout_q);
	assign abort       = (phase_q != PH_IDLE) && (silence_ext > timeout_ext);

	assign ph_cur   = abort ? PH_IDLE : phase_q;
	assign crc_cur  = abort ? CRC_INIT : crc_q;
	assign func_cur = abort ? 8'd0 : func_q;
	assign exp_cur  = abort ? 9'd0 : exp_q;
	assign rcv_cur  = abort ? 9'd0 : rcv_q;
	assign lo_cur   = abort ? 8'd0 : crc_lo_q;
	assign rcv_inc  = rcv_cur + 9'd1;

	// The CRC is at its initial value while idle, so one update serves every phase
	mbrx_crc8 u_crc (
		.crc_in  (crc_cur),
		.data    (byte_s1),
		.crc_out (crc_upd)
	);

	always_comb begin
		ph_n   = ph_cur;
		crc_n  = crc_cur;
		func_n = func_cur;
		exp_n  = exp_cur;
		rcv_n  = rcv_cur;
		lo_n   = lo_cur;
		st     = ST_IGNORED;
		idx    = 9'd0;
		val    = 8'd0;
		case (ph_cur)
			PH_IDLE: begin
				if (byte_s1 == station_q) begin
					crc_n = crc_upd;
					ph_n  = PH_ADDRESS;
					st    = ST_ADDRESS;
				end
			end
			PH_ADDRESS: begin
				func_n = byte_s1;
				crc_n  = crc_upd;
				rcv_n  = 9'd0;
				if (byte_s1 inside {[FC_FIXED_LO:FC_FIXED_HI]}) begin
					exp_n = LEN_FIXED;
				end else if (byte_s1 == FC_WRITE_MUL) begin
					exp_n = LEN_MUL_HEAD;
				end else begin
					exp_n = 9'd0;
				end
				if (exp_n == 9'd0) begin
					st = ST_BAD_FUNC;
				end else begin
					st   = ST_FUNCTION;
					ph_n = PH_DATA;
				end
			end
			PH_DATA: begin
				idx   = rcv_cur;
				val   = byte_s1;
				st    = ST_DATA;
				crc_n = crc_upd;
				rcv_n = rcv_inc;
				// Byte count of a multiple-register write extends the payload
				if (func_cur == FC_WRITE_MUL && rcv_inc == LEN_MUL_HEAD) begin
					exp_n = LEN_MUL_HEAD + {1'b0, byte_s1};
				end
				if (rcv_inc == exp_n) begin
					ph_n = PH_CRC_LOW;
				end
			end
			PH_CRC_LOW: begin
				lo_n = byte_s1;
				ph_n = PH_CRC_HIGH;
				st   = ST_CRC_LOW;
			end
			PH_CRC_HIGH: begin
				st = ({byte_s1, lo_cur} == crc_cur) ? ST_FRAME_OK : ST_CRC_ERR;
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase
	end

	// Advance frame state; ticks only move the silence counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			silence_q <= '0;
			crc_q     <= CRC_INIT;
			func_q    <= 8'd0;
			exp_q     <= 9'd0;
			rcv_q     <= 9'd0;
			crc_lo_q  <= 8'd0;
		end else if (advance) begin
			if (!is_byte) begin
				if (silence_q != SILENCE_MAX) begin
					silence_q <= silence_q + 1'b1;
				end
			end else begin
				silence_q <= '0;
				if (st inside {ST_BAD_FUNC, ST_FRAME_OK, ST_CRC_ERR}) begin
					phase_q  <= PH_IDLE;
					crc_q    <= CRC_INIT;
					func_q   <= 8'd0;
					exp_q    <= 9'd0;
					rcv_q    <= 9'd0;
					crc_lo_q <= 8'd0;
				end else begin
					phase_q  <= ph_n;
					crc_q    <= crc_n;
					func_q   <= func_n;
					exp_q    <= exp_n;
					rcv_q    <= rcv_n;
					crc_lo_q <= lo_n;
				end
			end
		end
	end

	// Result register: load on a byte, drop valid once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_byte) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_byte) begin
			status_q   <= st;
			abort_q    <= abort;
			func_out_q <= func_n;
			idx_q      <= idx;
			val_q      <= val;
			len_q      <= rcv_n;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.timeout_abort  = abort_q;
	assign rsp.function_code  = func_out_q;
	assign rsp.data_index     = idx_q;
	assign rsp.data_value     = val_q;
	assign rsp.payload_length = len_q;

endmodule

[hw/rtl/mbrx_crc8.sv]
// ----------------------------------------------------------------------------
// CRC-16/MODBUS byte update
// Folds one byte into the running CRC, eight reflected shift steps.
// ----------------------------------------------------------------------------
module mbrx_crc8
	import mbrx_pkg::*;
(
	input  logic [15:0] crc_in,
	input  logic [7:0]  data,
	output logic [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		crc_out = c;
	end

endmodule
